@@ hw/rtl/hidl_pkg.sv @@
// shared types and constants for the interpolated history delay line
package hidl_pkg;

  localparam int VAL_W     = 32;
  localparam int OP_W      = 2;
  localparam int POS_W     = 10;
  localparam int DIU_W     = 11;
  localparam int MU_W      = 16;
  localparam int FRAC_W    = 16;
  localparam int PROD_W    = VAL_W + 1 + MU_W + 1;
  localparam int VEC_N     = 4;
  localparam int CFG_IDX_W = 1;

  localparam logic [VAL_W-1:0] RECIP_RESET = 32'd655360;
  localparam logic [DIU_W-1:0] DEPTH_RESET = 11'd1024;

  localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
  localparam logic [OP_W-1:0] OP_DELAY = 2'd1;
  localparam logic [OP_W-1:0] OP_POS   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_RECIP = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_FETCH2,
    S_MULT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic we;
    logic cap_y1;
    logic cap_prod;
  } lane_ctl_t;

  typedef struct packed {
    logic done;
    logic oor;
    logic lerp;
  } merge_ctl_t;

endpackage

@@ hw/rtl/hidl_ram.sv @@
// generic single-write, single-read ram with registered read data
module hidl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/hidl_lane.sv @@
// one lane: history ram, floor sample capture and difference times fraction
module hidl_lane #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                              clk,
  input  hidl_pkg::lane_ctl_t               ctl,
  input  logic [AW-1:0]                     waddr,
  input  logic signed [hidl_pkg::VAL_W-1:0] wdata,
  input  logic [AW-1:0]                     raddr,
  input  logic [hidl_pkg::MU_W-1:0]         mu,
  output logic signed [hidl_pkg::VAL_W-1:0] y1,
  output logic signed [hidl_pkg::PROD_W-1:0] prod
);

  logic [hidl_pkg::VAL_W-1:0]         rdata;
  logic signed [hidl_pkg::VAL_W-1:0]  y1_r;
  logic signed [hidl_pkg::PROD_W-1:0] prod_r;
  logic signed [hidl_pkg::VAL_W:0]    diff;
  logic signed [hidl_pkg::MU_W:0]     mu_s;

  hidl_ram #(
    .WIDTH (hidl_pkg::VAL_W),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ctl.we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign diff = $signed({rdata[hidl_pkg::VAL_W-1], rdata}) - $signed({y1_r[hidl_pkg::VAL_W-1], y1_r});
  assign mu_s = $signed({1'b0, mu});

  always_ff @(posedge clk) begin
    if (ctl.cap_y1) begin
      y1_r <= $signed(rdata);
    end
    if (ctl.cap_prod) begin
      prod_r <= diff * mu_s;
    end
  end

  assign y1   = y1_r;
  assign prod = prod_r;

endmodule

@@ hw/rtl/hidl_merge.sv @@
// merge stage: combines lane results into the output register
module hidl_merge #(
  parameter int LANES = 4
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  hidl_pkg::merge_ctl_t               ctl,
  input  logic signed [hidl_pkg::VAL_W-1:0]  y1   [LANES],
  input  logic signed [hidl_pkg::PROD_W-1:0] prod [LANES],
  input  logic                               out_stall,
  output logic                               free,
  output logic                               out_valid,
  output logic signed [hidl_pkg::VAL_W-1:0]  res  [hidl_pkg::VEC_N],
  output logic                               res_oor
);

  logic                              valid_r;
  logic                              oor_r;
  logic signed [hidl_pkg::VAL_W-1:0] data_r [LANES];
  logic signed [hidl_pkg::VAL_W-1:0] data_nxt [LANES];
  logic                              load;

  assign free = !valid_r || !out_stall;
  assign load = ctl.done && free;

  always_comb begin
    logic signed [hidl_pkg::PROD_W-1:0] sum;
    for (int k = 0; k < LANES; k++) begin
      sum = hidl_pkg::PROD_W'(y1[k]) + (prod[k] >>> hidl_pkg::FRAC_W);
      if (ctl.oor) begin
        data_nxt[k] = '0;
      end else if (ctl.lerp) begin
        data_nxt[k] = sum[hidl_pkg::VAL_W-1:0];
      end else begin
        data_nxt[k] = y1[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= data_nxt;
      oor_r  <= ctl.oor;
    end
  end

  for (genvar k = 0; k < hidl_pkg::VEC_N; k++) begin : g_out
    if (k < LANES) begin : g_used
      assign res[k] = data_r[k];
    end else begin : g_unused
      assign res[k] = '0;
    end
  end

  assign out_valid = valid_r;
  assign res_oor   = oor_r;

endmodule

@@ hw/rtl/interpolated_history_delay_line_top.sv @@
// top level of the interpolated history delay line: control, lanes and merge
//
// channel  ports                                       handshake
// input    in_op, in_delay, in_position, in_value_0..3 in_valid / in_stall
// output   out_0..out_3, out_of_range                  out_valid / out_stall
// config   cfg_index, cfg_wdata                        cfg_we
//
// a push does not stall the input and the block is ready again the next cycle
// a read goes check, fetch2, mult (zero fraction skips mult, out of range both)
// then loads the output register; each lane ram's single read port sets this
// reset clears control state; ram contents are undefined until pushed
// while the output register is stalled the block holds a finished read
module interpolated_history_delay_line_top #(
  parameter int LANES = 4,
  parameter int DEPTH = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [hidl_pkg::OP_W-1:0]            in_op,
  input  logic [hidl_pkg::VAL_W-1:0]           in_delay,
  input  logic [hidl_pkg::POS_W-1:0]           in_position,
  input  logic signed [hidl_pkg::VAL_W-1:0]    in_value_0,
  input  logic signed [hidl_pkg::VAL_W-1:0]    in_value_1,
  input  logic signed [hidl_pkg::VAL_W-1:0]    in_value_2,
  input  logic signed [hidl_pkg::VAL_W-1:0]    in_value_3,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [hidl_pkg::VAL_W-1:0]    out_0,
  output logic signed [hidl_pkg::VAL_W-1:0]    out_1,
  output logic signed [hidl_pkg::VAL_W-1:0]    out_2,
  output logic signed [hidl_pkg::VAL_W-1:0]    out_3,
  output logic                                 out_of_range,
  input  logic                                 cfg_we,
  input  logic [hidl_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [hidl_pkg::VAL_W-1:0]           cfg_wdata
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = (CW > hidl_pkg::DIU_W) ? CW : hidl_pkg::DIU_W;
  localparam int IW = 2 * hidl_pkg::VAL_W;

  hidl_pkg::state_t state_r, state_nxt;

  logic [hidl_pkg::VAL_W-1:0] recip_r;
  logic [hidl_pkg::DIU_W-1:0] depth_r;
  logic [AW-1:0]              write_slot_r, write_slot_nxt;
  logic [CW-1:0]              fill_r, fill_nxt;
  logic [hidl_pkg::OP_W-1:0]  op_r;
  logic [IW-1:0]              prod_r;
  logic [hidl_pkg::POS_W-1:0] pos_r;
  logic [AW-1:0]              slot_r;
  logic [hidl_pkg::MU_W-1:0]  mu_r;
  logic                       oor_r;

  logic                       accept;
  logic [CW-1:0]              eff;
  logic [CW-1:0]              count;
  logic [CW:0]                count_inc;
  logic [hidl_pkg::VAL_W-1:0] idx;
  logic [hidl_pkg::MU_W-1:0]  mu;
  logic                       oor;
  logic [AW:0]                slot_diff;
  logic [AW-1:0]              slot1;
  logic [AW-1:0]              slot2;
  logic [AW-1:0]              raddr;

  hidl_pkg::lane_ctl_t        lane_ctl;
  hidl_pkg::merge_ctl_t       merge_ctl;
  logic                       free;

  logic signed [hidl_pkg::VAL_W-1:0]  vals  [hidl_pkg::VEC_N];
  logic signed [hidl_pkg::VAL_W-1:0]  y1    [LANES];
  logic signed [hidl_pkg::PROD_W-1:0] prod  [LANES];
  logic signed [hidl_pkg::VAL_W-1:0]  res   [hidl_pkg::VEC_N];

  assign accept = in_valid && !in_stall;
  assign in_stall = (state_r != hidl_pkg::S_IDLE);

  // effective depth and valid count
  always_comb begin
    if (depth_r == '0) begin
      eff = CW'(1);
    end else if (EW'(depth_r) > EW'(DEPTH)) begin
      eff = CW'(DEPTH);
    end else begin
      eff = CW'(depth_r);
    end
    count     = (fill_r < eff) ? fill_r : eff;
    count_inc = {1'b0, count} + (CW + 1)'(1);
    fill_nxt  = (count_inc < {1'b0, eff}) ? count_inc[CW-1:0] : eff;
    write_slot_nxt = (write_slot_r == AW'(DEPTH - 1)) ? '0 : write_slot_r + AW'(1);
  end

  // index, fraction and range check of a read
  always_comb begin
    if (op_r == hidl_pkg::OP_POS) begin
      idx = hidl_pkg::VAL_W'(pos_r);
      mu  = '0;
    end else begin
      idx = prod_r[IW-1:hidl_pkg::VAL_W];
      mu  = prod_r[hidl_pkg::VAL_W-1:hidl_pkg::VAL_W-hidl_pkg::MU_W];
    end
    oor = ({1'b0, idx} >= (hidl_pkg::VAL_W + 1)'(count))
       || ((mu != '0)
           && (({1'b0, idx} + (hidl_pkg::VAL_W + 1)'(1)) >= (hidl_pkg::VAL_W + 1)'(count)));
    slot_diff = {1'b0, write_slot_r} - {1'b0, idx[AW-1:0]} - (AW + 1)'(1);
    if (slot_diff[AW]) begin
      slot1 = slot_diff[AW-1:0] + AW'(DEPTH);
    end else begin
      slot1 = slot_diff[AW-1:0];
    end
    slot2 = (slot_r == '0) ? AW'(DEPTH - 1) : slot_r - AW'(1);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      hidl_pkg::S_IDLE: begin
        if (accept) begin
          case (in_op) inside
            hidl_pkg::OP_DELAY, hidl_pkg::OP_POS: state_nxt = hidl_pkg::S_CHECK;
            default: state_nxt = hidl_pkg::S_IDLE;
          endcase
        end
      end
      hidl_pkg::S_CHECK: begin
        state_nxt = oor ? hidl_pkg::S_DONE : hidl_pkg::S_FETCH2;
      end
      hidl_pkg::S_FETCH2: begin
        state_nxt = (mu_r == '0) ? hidl_pkg::S_DONE : hidl_pkg::S_MULT;
      end
      hidl_pkg::S_MULT: begin
        state_nxt = hidl_pkg::S_DONE;
      end
      hidl_pkg::S_DONE: begin
        if (free) begin
          state_nxt = hidl_pkg::S_IDLE;
        end
      end
      default: state_nxt = hidl_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    lane_ctl  = '0;
    merge_ctl = '0;
    raddr     = slot_r;
    unique case (state_r)
      hidl_pkg::S_IDLE: begin
        lane_ctl.we = accept && (in_op == hidl_pkg::OP_PUSH);
      end
      hidl_pkg::S_CHECK: begin
        raddr = slot1;
      end
      hidl_pkg::S_FETCH2: begin
        lane_ctl.cap_y1 = 1'b1;
        raddr = slot2;
      end
      hidl_pkg::S_MULT: begin
        lane_ctl.cap_prod = 1'b1;
      end
      hidl_pkg::S_DONE: begin
        merge_ctl.done = 1'b1;
        merge_ctl.oor  = oor_r;
        merge_ctl.lerp = (mu_r != '0);
      end
      default: begin
        lane_ctl  = '0;
        merge_ctl = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= hidl_pkg::S_IDLE;
      recip_r      <= hidl_pkg::RECIP_RESET;
      depth_r      <= hidl_pkg::DEPTH_RESET;
      write_slot_r <= '0;
      fill_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          hidl_pkg::CFG_RECIP: recip_r <= cfg_wdata;
          hidl_pkg::CFG_DEPTH: depth_r <= cfg_wdata[hidl_pkg::DIU_W-1:0];
        endcase
      end
      if (lane_ctl.we) begin
        write_slot_r <= write_slot_nxt;
        fill_r       <= fill_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_op;
      pos_r  <= in_position;
      prod_r <= IW'(in_delay) * IW'(recip_r);
    end
    if (state_r == hidl_pkg::S_CHECK) begin
      oor_r  <= oor;
      mu_r   <= mu;
      slot_r <= slot1;
    end
  end

  assign vals[0] = in_value_0;
  assign vals[1] = in_value_1;
  assign vals[2] = in_value_2;
  assign vals[3] = in_value_3;

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    hidl_lane #(
      .DEPTH (DEPTH),
      .AW    (AW)
    ) u_lane (
      .clk   (clk),
      .ctl   (lane_ctl),
      .waddr (write_slot_r),
      .wdata (vals[k]),
      .raddr (raddr),
      .mu    (mu_r),
      .y1    (y1[k]),
      .prod  (prod[k])
    );
  end

  hidl_merge #(
    .LANES (LANES)
  ) u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (merge_ctl),
    .y1        (y1),
    .prod      (prod),
    .out_stall (out_stall),
    .free      (free),
    .out_valid (out_valid),
    .res       (res),
    .res_oor   (out_of_range)
  );

  assign out_0 = res[0];
  assign out_1 = res[1];
  assign out_2 = res[2];
  assign out_3 = res[3];

endmodule
